FILE: rtl/tlp_pkg.sv
package tlp_pkg;

    localparam int unsigned NUM_PFX = 5;

    localparam logic [2:0] BODY_POS = 3'd5;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [2:0] KIND_TEMP    = 3'd0;
    localparam logic [2:0] KIND_DIST    = 3'd1;
    localparam logic [2:0] KIND_CURRENT = 3'd2;
    localparam logic [2:0] KIND_VOLTAGE = 3'd3;
    localparam logic [2:0] KIND_DEBUG   = 3'd4;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_DIGITS = 2'd1;
    localparam logic [1:0] STATUS_RANGE     = 2'd2;

    localparam logic [35:0] MAG_LIMIT = 36'h0_8000_0000;

    typedef struct packed {
        logic [7:0] rx_byte;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  line_kind;
        logic [15:0] reading;
        logic [1:0]  parse_status;
    } out_word_t;

    typedef struct packed {
        logic [2:0] position;
        logic [4:0] candidates;
    } pfx_state_t;

    typedef struct packed {
        logic        negative;
        logic [31:0] magnitude;
        logic        digit_seen;
        logic        range_exceeded;
    } num_state_t;

    function automatic logic [2:0] pfx_len(input logic [2:0] kind);
        logic [2:0] len;
        len = (kind == KIND_DEBUG) ? 3'd3 : 3'd5;
        return len;
    endfunction

    function automatic logic [7:0] pfx_char(input logic [2:0] kind, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        unique case (kind)
            KIND_TEMP:
            begin
                case (pos)
                    3'd0: ch = "t";
                    3'd1: ch = "m";
                    3'd2: ch = "p";
                    3'd3: ch = ":";
                    3'd4: ch = " ";
                    default: ch = 8'h00;
                endcase
            end
            KIND_DIST:
            begin
                case (pos)
                    3'd0: ch = "d";
                    3'd1: ch = "s";
                    3'd2: ch = "t";
                    3'd3: ch = ":";
                    3'd4: ch = " ";
                    default: ch = 8'h00;
                endcase
            end
            KIND_CURRENT:
            begin
                case (pos)
                    3'd0: ch = "a";
                    3'd1: ch = "m";
                    3'd2: ch = "p";
                    3'd3: ch = ":";
                    3'd4: ch = " ";
                    default: ch = 8'h00;
                endcase
            end
            KIND_VOLTAGE:
            begin
                case (pos)
                    3'd0: ch = "v";
                    3'd1: ch = "l";
                    3'd2: ch = "t";
                    3'd3: ch = ":";
                    3'd4: ch = " ";
                    default: ch = 8'h00;
                endcase
            end
            KIND_DEBUG:
            begin
                case (pos)
                    3'd0: ch = "d";
                    3'd1: ch = ":";
                    3'd2: ch = " ";
                    default: ch = 8'h00;
                endcase
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

FILE: rtl/tlp_stream_if.sv
interface tlp_stream_if #(
    parameter type payload_t = logic [7:0]
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

FILE: rtl/tlp_prefix_match.sv
module tlp_prefix_match (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          rx_byte,
    output tlp_pkg::pfx_state_t state
);

    logic [2:0] position_reg;
    logic [2:0] position_next;
    logic [4:0] candidates_reg;
    logic [4:0] candidates_next;

    always_comb
    begin
        position_next   = position_reg;
        candidates_next = candidates_reg;
        if (step)
        begin
            if (rx_byte == tlp_pkg::CHAR_LF)
            begin
                position_next   = 3'd0;
                candidates_next = 5'b11111;
            end
            else if (position_reg < tlp_pkg::BODY_POS)
            begin
                for (int k = 0; k < tlp_pkg::NUM_PFX; k++)
                begin
                    if (candidates_reg[k] &&
                        position_reg < tlp_pkg::pfx_len(3'(k)) &&
                        tlp_pkg::pfx_char(3'(k), position_reg) != rx_byte)
                    begin
                        candidates_next[k] = 1'b0;
                    end
                end
                position_next = position_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg   <= 3'd0;
            candidates_reg <= 5'b11111;
        end
        else
        begin
            position_reg   <= position_next;
            candidates_reg <= candidates_next;
        end
    end

    assign state.position   = position_reg;
    assign state.candidates = candidates_reg;

endmodule

FILE: rtl/tlp_number_acc.sv
module tlp_number_acc (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                in_body,
    input  logic [7:0]          rx_byte,
    output tlp_pkg::num_state_t state
);

    localparam logic [1:0] PH_SPACE  = 2'd0;
    localparam logic [1:0] PH_SIGN   = 2'd1;
    localparam logic [1:0] PH_DIGITS = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    logic [1:0]  phase_reg;
    logic [1:0]  phase_next;
    logic        negative_reg;
    logic        negative_next;
    logic [31:0] magnitude_reg;
    logic [31:0] magnitude_next;
    logic        seen_reg;
    logic        seen_next;
    logic        range_reg;
    logic        range_next;

    logic        is_digit;
    logic        is_space;
    logic        take_digit;
    logic [35:0] product;

    assign is_digit = (rx_byte >= tlp_pkg::CHAR_ZERO) && (rx_byte <= tlp_pkg::CHAR_NINE);
    assign is_space = (rx_byte == tlp_pkg::CHAR_SPACE) ||
                      ((rx_byte >= tlp_pkg::CHAR_TAB) && (rx_byte <= tlp_pkg::CHAR_CR));
    assign product  = ({4'd0, magnitude_reg} << 3) + ({4'd0, magnitude_reg} << 1) +
                      {32'd0, rx_byte[3:0]};

    always_comb
    begin
        phase_next     = phase_reg;
        negative_next  = negative_reg;
        magnitude_next = magnitude_reg;
        seen_next      = seen_reg;
        range_next     = range_reg;
        take_digit     = 1'b0;

        if (step && rx_byte == tlp_pkg::CHAR_LF)
        begin
            phase_next     = PH_SPACE;
            negative_next  = 1'b0;
            magnitude_next = 32'd0;
            seen_next      = 1'b0;
            range_next     = 1'b0;
        end
        else if (step && in_body)
        begin
            unique case (phase_reg)
                PH_SPACE:
                begin
                    if (is_space)
                    begin
                        phase_next = PH_SPACE;
                    end
                    else if (rx_byte == tlp_pkg::CHAR_PLUS || rx_byte == tlp_pkg::CHAR_MINUS)
                    begin
                        negative_next = (rx_byte == tlp_pkg::CHAR_MINUS);
                        phase_next    = PH_SIGN;
                    end
                    else if (is_digit)
                    begin
                        take_digit = 1'b1;
                        phase_next = PH_DIGITS;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
                PH_SIGN, PH_DIGITS:
                begin
                    if (is_digit)
                    begin
                        take_digit = 1'b1;
                        phase_next = PH_DIGITS;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase

            if (take_digit)
            begin
                seen_next = 1'b1;
                if (product > tlp_pkg::MAG_LIMIT)
                begin
                    range_next = 1'b1;
                end
                else
                begin
                    magnitude_next = product[31:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SPACE;
            negative_reg  <= 1'b0;
            magnitude_reg <= 32'd0;
            seen_reg      <= 1'b0;
            range_reg     <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            negative_reg  <= negative_next;
            magnitude_reg <= magnitude_next;
            seen_reg      <= seen_next;
            range_reg     <= range_next;
        end
    end

    assign state.negative       = negative_reg;
    assign state.magnitude      = magnitude_reg;
    assign state.digit_seen     = seen_reg;
    assign state.range_exceeded = range_reg;

endmodule

FILE: rtl/telemetry_line_parser.sv
// Telemetry line parser.
// The rx channel carries one received ASCII byte per word. Bytes are cut into
// lines at newline, and each line that opens with "tmp: ", "dst: ", "amp: ",
// "vlt: " or "d: " gives one word on the res channel when its newline
// arrives: the line kind, the 16-bit reading and a parse status.
// Lines with no known prefix give no word.
// Each accepted byte is held in an input register until it is consumed; a result
// word is registered when its newline is consumed. Throughput is one byte
// per cycle while res is not stalled; the per-byte work is a prefix compare and
// one multiply-by-ten accumulate into the prefix and number state registers.
// When res is stalled with a word pending, the byte in the input register
// waits and rx takes at most that one more byte before ready drops.
// Reset empties both registers and returns the parser to the start of a line.
module telemetry_line_parser (
    input  logic          clk,
    input  logic          rst_n,
    tlp_stream_if.sink    rx,
    tlp_stream_if.source  res
);

    logic                rx_valid_reg;
    logic [7:0]          rx_byte_reg;
    logic                res_valid_reg;
    tlp_pkg::out_word_t  res_word_reg;

    logic                consume;
    logic                is_lf;
    logic                in_body;
    logic                hit;
    logic [2:0]          kind;
    logic                over;
    logic [31:0]         signed_value;
    tlp_pkg::out_word_t  word_next;
    tlp_pkg::pfx_state_t pfx_state;
    tlp_pkg::num_state_t num_state;

    assign consume  = rx_valid_reg && (!res_valid_reg || res.ready);
    assign rx.ready = !rx_valid_reg || consume;
    assign is_lf    = (rx_byte_reg == tlp_pkg::CHAR_LF);
    assign in_body  = (pfx_state.position == tlp_pkg::BODY_POS) &&
                      (pfx_state.candidates[3:0] != 4'd0);

    tlp_prefix_match u_prefix (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (consume),
        .rx_byte (rx_byte_reg),
        .state   (pfx_state)
    );

    tlp_number_acc u_number (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (consume),
        .in_body (in_body),
        .rx_byte (rx_byte_reg),
        .state   (num_state)
    );

    always_comb
    begin
        hit  = 1'b0;
        kind = tlp_pkg::KIND_TEMP;
        for (int k = 0; k < tlp_pkg::NUM_PFX; k++)
        begin
            if (!hit && pfx_state.candidates[k] &&
                pfx_state.position >= tlp_pkg::pfx_len(3'(k)))
            begin
                hit  = 1'b1;
                kind = 3'(k);
            end
        end

        over         = num_state.range_exceeded ||
                       (!num_state.negative && num_state.magnitude[31]);
        signed_value = num_state.negative ? (~num_state.magnitude + 32'd1)
                                          : num_state.magnitude;

        word_next.line_kind    = kind;
        word_next.reading      = 16'd0;
        word_next.parse_status = tlp_pkg::STATUS_OK;
        if (kind != tlp_pkg::KIND_DEBUG)
        begin
            if (!num_state.digit_seen)
            begin
                word_next.parse_status = tlp_pkg::STATUS_NO_DIGITS;
            end
            else if (over)
            begin
                word_next.parse_status = tlp_pkg::STATUS_RANGE;
            end
            else
            begin
                word_next.reading = signed_value[15:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (rx.ready)
            begin
                rx_valid_reg <= rx.valid;
            end
            if (consume && is_lf && hit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            rx_byte_reg <= rx.payload.rx_byte;
        end
        if (consume && is_lf && hit)
        begin
            res_word_reg <= word_next;
        end
    end

    assign res.valid   = res_valid_reg;
    assign res.payload = res_word_reg;

endmodule

FILE: rtl/tlp_checker.sv
module tlp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic [2:0]  line_kind,
    input logic [15:0] reading,
    input logic [1:0]  parse_status
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(line_kind) &&
        $stable(reading) && $stable(parse_status))
    else $error("result word changed while stalled");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> line_kind <= tlp_pkg::KIND_DEBUG)
    else $error("line kind out of range");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && parse_status != tlp_pkg::STATUS_OK |->
        reading == 16'd0 &&
        (parse_status == tlp_pkg::STATUS_NO_DIGITS || parse_status == tlp_pkg::STATUS_RANGE))
    else $error("error result with nonzero reading or bad status");

    a_debug_plain: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && line_kind == tlp_pkg::KIND_DEBUG |->
        reading == 16'd0 && parse_status == tlp_pkg::STATUS_OK)
    else $error("debug line result carries a value or status");

endmodule

bind telemetry_line_parser tlp_checker u_tlp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .line_kind    (res.payload.line_kind),
    .reading      (res.payload.reading),
    .parse_status (res.payload.parse_status)
);
